// ----- src/searchable_stack_core_assert.svh -----
// Assertion macros used by the RTL. The using module supplies clk and arst_n.
`ifndef SEARCHABLE_STACK_CORE_ASSERT_SVH
`define SEARCHABLE_STACK_CORE_ASSERT_SVH

// same-cycle implication
`define SSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("searchable_stack_core: same-cycle check failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("searchable_stack_core: next-cycle check failed");

`endif

// ----- src/ss_pkg.sv -----
`default_nettype none
package ss_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_FIND  = 3'd3,
		CMD_DEL   = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic signed [DATA_W-1:0]  value;
		logic        [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  value_out;
		logic        [POS_W-1:0]   found_position;
		logic        [COUNT_W-1:0] count;
		status_t                   status;
	} rsp_t;

	// shift controls broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
		logic del;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/ss_cell.sv -----
`default_nettype none
// One stack slot. Cell 0 is the top; data moves down on push, up on pop,
// and up for every cell at or below the topmost match on delete.
module ss_cell (
	input  wire logic                             clk,
	input  wire logic                             occupied,
	input  wire logic signed [ss_pkg::DATA_W-1:0] key,
	input  wire ss_pkg::cell_ctl_t                ctl,
	input  wire logic signed [ss_pkg::DATA_W-1:0] above,
	input  wire logic signed [ss_pkg::DATA_W-1:0] below,
	input  wire logic                             hit_in,
	output logic signed [ss_pkg::DATA_W-1:0]      data,
	output logic                                  match,
	output logic                                  hit_out
);

	logic signed [ss_pkg::DATA_W-1:0] data_q;

	assign data    = data_q;
	assign match   = occupied && (data_q == key);
	assign hit_out = hit_in || match;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= above;
		end else if (ctl.pop || (ctl.del && hit_out)) begin
			data_q <= below;
		end
	end

endmodule
`default_nettype wire

// ----- src/searchable_stack_core.sv -----
`default_nettype none
// Bounded LIFO of signed 32-bit words with search, delete and indexed read.
// One item is taken every clock cycle while req_stall is low; its response appears
// in the output register on the next cycle. The rate is set by the row of
// stack cells: each command compares the key in every cell at once and
// shifts the whole row together. Input stall is raised only while
// a response waits in the output register and the output is stalled.
// There is no memory and no clearing pass: the stack is usable right after reset.
`include "searchable_stack_core_assert.svh"
module searchable_stack_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire ss_pkg::req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output ss_pkg::rsp_t      rsp
);

	localparam int D  = ss_pkg::DEPTH;
	localparam int CW = ss_pkg::CNT_W;

	logic                             acc;
	logic [CW-1:0]                    cnt_q, cnt_d;
	logic                             rsp_valid_q;
	ss_pkg::rsp_t                     rsp_q, rsp_d;
	ss_pkg::cell_ctl_t                ctl;
	logic signed [ss_pkg::DATA_W-1:0] cell_data [D];
	logic        [D:0]                hit;
	logic        [D-1:0]              match;
	logic        [D-1:0]              first;
	logic                             empty, full, any_hit, past_end;
	logic        [ss_pkg::IDX_W-1:0]  rd_idx;
	logic        [ss_pkg::POS_W-1:0]  fpos;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(D));
	assign hit[0]  = 1'b0;
	assign any_hit = hit[D];

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			logic signed [ss_pkg::DATA_W-1:0] above_w, below_w;
			if (g == 0) begin : g_top
				assign above_w = req.value;
			end else begin : g_mid
				assign above_w = cell_data[g-1];
			end
			if (g == D - 1) begin : g_bot
				assign below_w = cell_data[g];
			end else begin : g_up
				assign below_w = cell_data[g+1];
			end
			ss_cell u_cell (
				.clk     (clk),
				.occupied(CW'(g) < cnt_q),
				.key     (req.value),
				.ctl     (ctl),
				.above   (above_w),
				.below   (below_w),
				.hit_in  (hit[g]),
				.data    (cell_data[g]),
				.match   (match[g]),
				.hit_out (hit[g+1])
			);
			assign first[g] = match[g] && !hit[g];
		end
	endgenerate

	// read past the bottom falls back to the deepest entry
	always_comb begin
		logic [ss_pkg::CMP_W-1:0] pos_x;
		logic [ss_pkg::CMP_W-1:0] cnt_x;
		pos_x    = ss_pkg::CMP_W'(req.position);
		cnt_x    = ss_pkg::CMP_W'(cnt_q);
		past_end = (pos_x >= cnt_x);
		rd_idx   = past_end ? ss_pkg::IDX_W'(cnt_q - 1'b1) : ss_pkg::IDX_W'(pos_x);
	end

	always_comb begin
		fpos = '0;
		for (int i = 0; i < D; i++) begin
			if (first[i]) begin
				fpos = fpos | ss_pkg::POS_W'(i);
			end
		end
	end

	always_comb begin
		ctl                  = '0;
		cnt_d                = cnt_q;
		rsp_d.value_out      = '0;
		rsp_d.found_position = '0;
		rsp_d.status         = ss_pkg::ST_OK;
		unique case (req.cmd)
			ss_pkg::CMD_PUSH: begin
				if (full) begin
					rsp_d.status = ss_pkg::ST_FULL;
				end else begin
					ctl.push = acc;
					cnt_d    = cnt_q + 1'b1;
				end
			end
			ss_pkg::CMD_POP: begin
				if (empty) begin
					rsp_d.value_out = '1;
					rsp_d.status    = ss_pkg::ST_EMPTY;
				end else begin
					ctl.pop         = acc;
					cnt_d           = cnt_q - 1'b1;
					rsp_d.value_out = cell_data[0];
				end
			end
			ss_pkg::CMD_CLEAR: begin
				cnt_d = '0;
			end
			ss_pkg::CMD_FIND: begin
				if (any_hit) begin
					rsp_d.found_position = fpos;
				end else begin
					rsp_d.status = ss_pkg::ST_NOTFOUND;
				end
			end
			ss_pkg::CMD_DEL: begin
				if (empty) begin
					rsp_d.status = ss_pkg::ST_EMPTY;
				end else if (!any_hit) begin
					rsp_d.status = ss_pkg::ST_NOTFOUND;
				end else begin
					ctl.del = acc;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			ss_pkg::CMD_READ: begin
				if (empty) begin
					rsp_d.status = ss_pkg::ST_EMPTY;
				end else begin
					rsp_d.value_out = cell_data[rd_idx];
				end
			end
			default: begin
			end
		endcase
		rsp_d.count = ss_pkg::COUNT_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_d;
		end
	end

	`SSC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CW'(D))
	`SSC_ASSERT_NOW(a_first_onehot, 1'b1, $onehot0(first))
	`SSC_ASSERT_NEXT(a_push_grows, acc && req.cmd == ss_pkg::CMD_PUSH && !full,
		cnt_q == $past(cnt_q) + 1'b1)
	`SSC_ASSERT_NEXT(a_del_shrinks, acc && req.cmd == ss_pkg::CMD_DEL && any_hit,
		cnt_q == $past(cnt_q) - 1'b1)

endmodule
`default_nettype wire
